### src/byte_ring_buffer_peek_erase_macros.svh
// ----------------------------------------------------------------------------
// Byte ring buffer assertion macros
// Concurrent assertion wrappers, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_BUFFER_PEEK_ERASE_MACROS_SVH
`define BYTE_RING_BUFFER_PEEK_ERASE_MACROS_SVH

`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define BRB_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// antecedent implies consequent in the next cycle
`define BRB_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BRB_ASSERT_IMP(label, ante, cons, msg)
`define BRB_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

### src/brb_pkg.sv
// ----------------------------------------------------------------------------
// brb_pkg
// Types and codes shared by the byte ring buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package brb_pkg;

	localparam int CNT_W  = 7;
	localparam int BYTE_W = 8;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_DRAIN = 2'd1,
		OP_PEEK  = 2'd2,
		OP_ERASE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_RUN  = 1'b1
	} state_t;

endpackage

`default_nettype wire

### src/brb_mem.sv
// ----------------------------------------------------------------------------
// brb_mem
// Byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module brb_mem import brb_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [AW-1:0]     waddr,
	input  wire logic [BYTE_W-1:0] wdata,
	input  wire logic [AW-1:0]     raddr,
	output logic      [BYTE_W-1:0] rdata
);

	logic [BYTE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### src/byte_ring_buffer_peek_erase.sv
// ----------------------------------------------------------------------------
// byte_ring_buffer_peek_erase
// Byte ring buffer with write, drain, peek and erase over one byte store.
//
//   channel  handshake            payload
//   command  start / busy         opcode, data_byte, erase_count
//   result   strobe (1 cycle)     out_byte, last, status, occupancy, full_res
//
// Write and erase: busy stays low; the result is registered and strobed in the cycle after accept.
// Drain/peek of n bytes: results follow accept back to back, one byte per
// cycle read from the store port; busy is high until the last byte.
// Empty drain/peek: a single result, in the cycle after accept.
// Reset clears head, tail and count; store contents are not cleared.
// Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_ring_buffer_peek_erase import brb_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [1:0]        opcode,
	input  wire logic [BYTE_W-1:0] data_byte,
	input  wire logic [CNT_W-1:0]  erase_count,
	output logic                   strobe,
	output logic      [BYTE_W-1:0] out_byte,
	output logic                   last,
	output logic      [1:0]        status,
	output logic      [CNT_W-1:0]  occupancy,
	output logic                   full_res
);

`include "byte_ring_buffer_peek_erase_macros.svh"

	localparam int AW = $clog2(DEPTH);
	localparam int SW = CNT_W + 1;

	state_t           state_q, state_d;
	logic [AW-1:0]    head_q, tail_q, ptr_q;
	logic [CNT_W-1:0] count_q, rem_q;
	logic             res_q;
	status_t          stat_q;

	logic              accept, is_full, is_empty, start_run;
	op_t               op;
	logic [CNT_W-1:0]  erase_n;
	logic [SW-1:0]     head_sum, head_wrap;
	logic [AW-1:0]     raddr;
	logic              we;
	logic [BYTE_W-1:0] rdata;

	function automatic logic [AW-1:0] adv1(input logic [AW-1:0] idx);
		return (idx == AW'(DEPTH - 1)) ? '0 : idx + 1'b1;
	endfunction

	assign op       = op_t'(opcode);
	assign accept   = start && !busy;
	assign is_full  = (count_q == CNT_W'(DEPTH));
	assign is_empty = (count_q == '0);
	assign start_run = accept && (op == OP_DRAIN || op == OP_PEEK) && !is_empty;

	assign erase_n   = (erase_count < count_q) ? erase_count : count_q;
	assign head_sum  = SW'(head_q) + SW'(erase_n);
	assign head_wrap = (head_sum >= SW'(DEPTH)) ? head_sum - SW'(DEPTH) : head_sum;

	assign we    = accept && (op == OP_WRITE) && !is_full;
	assign raddr = accept ? head_q : ptr_q;

	brb_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (tail_q),
		.wdata (data_byte),
		.raddr (raddr),
		.rdata (rdata)
	);

	// next state
	always_comb begin
		if (start_run) begin
			state_d = S_RUN;
		end else if (state_q == S_RUN && rem_q != CNT_W'(1)) begin
			state_d = S_RUN;
		end else begin
			state_d = S_IDLE;
		end
	end

	// outputs
	always_comb begin
		unique case (state_q)
			S_RUN: begin
				busy     = (rem_q != CNT_W'(1));
				strobe   = 1'b1;
				out_byte = rdata;
				last     = (rem_q == CNT_W'(1));
				status   = STAT_OK;
			end
			default: begin
				busy     = 1'b0;
				strobe   = res_q;
				out_byte = '0;
				last     = 1'b1;
				status   = stat_q;
			end
		endcase
		occupancy = count_q;
		full_res  = (count_q == CNT_W'(DEPTH));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			rem_q   <= '0;
			ptr_q   <= '0;
			res_q   <= 1'b0;
			stat_q  <= STAT_OK;
		end else begin
			state_q <= state_d;
			res_q   <= 1'b0;
			if (state_q == S_RUN) begin
				ptr_q <= adv1(ptr_q);
				rem_q <= rem_q - 1'b1;
			end
			if (accept) begin
				unique case (op)
					OP_WRITE: begin
						res_q  <= 1'b1;
						stat_q <= is_full ? STAT_FULL : STAT_OK;
						if (!is_full) begin
							tail_q  <= adv1(tail_q);
							count_q <= count_q + 1'b1;
						end
					end
					OP_ERASE: begin
						res_q   <= 1'b1;
						stat_q  <= STAT_OK;
						head_q  <= head_wrap[AW-1:0];
						count_q <= count_q - erase_n;
					end
					OP_DRAIN, OP_PEEK: begin
						if (is_empty) begin
							res_q  <= 1'b1;
							stat_q <= STAT_EMPTY;
						end else begin
							rem_q <= count_q;
							ptr_q <= adv1(head_q);
							if (op == OP_DRAIN) begin
								head_q  <= tail_q;
								count_q <= '0;
							end
						end
					end
				endcase
			end
		end
	end

	`BRB_ASSERT_IMP(a_count_range, 1'b1, count_q <= CNT_W'(DEPTH), "count above depth")
	`BRB_ASSERT_IMP(a_empty_ptrs, count_q == '0, head_q == tail_q, "empty with head != tail")
	`BRB_ASSERT_IMP(a_run_rem, state_q == S_RUN, rem_q != '0, "run with no bytes left")
	`BRB_ASSERT_NXT(a_drain_clears, start_run && op == OP_DRAIN,
		count_q == '0 && state_q == S_RUN, "drain did not empty buffer")
	`BRB_ASSERT_IMP(a_res_idle, res_q, state_q == S_IDLE, "single result during run")

endmodule

`default_nettype wire

### sim/brb_checker.sv
// ----------------------------------------------------------------------------
// brb_checker
// Tracks the byte ring (store, head, tail, fill) from every accepted command
// transaction, queues the result transactions each one must produce, and
// compares every strobed result field by field against the oldest one due.
// ----------------------------------------------------------------------------
`default_nettype none

module brb_checker import brb_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              busy,
	input  wire logic [1:0]        opcode,
	input  wire logic [BYTE_W-1:0] data_byte,
	input  wire logic [CNT_W-1:0]  erase_count,
	input  wire logic              strobe,
	input  wire logic [BYTE_W-1:0] out_byte,
	input  wire logic              last,
	input  wire logic [1:0]        status,
	input  wire logic [CNT_W-1:0]  occupancy,
	input  wire logic              full_res,
	output int                     mismatches,
	output int                     due_count
);

	typedef struct {
		logic [BYTE_W-1:0] value;
		logic              is_last;
		status_t           stat;
		logic [CNT_W-1:0]  occ;
		logic              full;
	} ring_result_t;

	ring_result_t      due_results[$];
	logic [BYTE_W-1:0] ring [DEPTH];
	int unsigned       head_pos = 0;
	int unsigned       tail_pos = 0;
	int unsigned       fill = 0;

	function automatic void push_result(logic [BYTE_W-1:0] value, logic is_last,
			status_t stat);
		ring_result_t r;
		r.value   = value;
		r.is_last = is_last;
		r.stat    = stat;
		r.occ     = fill[CNT_W-1:0];
		r.full    = (fill == DEPTH);
		due_results.push_back(r);
	endfunction

	function automatic void apply_ring_op(op_t op, logic [BYTE_W-1:0] d,
			logic [CNT_W-1:0] n);
		int unsigned k;
		int unsigned cnt;
		int unsigned idx;
		unique case (op)
			OP_WRITE: begin
				if (fill < DEPTH) begin
					ring[tail_pos] = d;
					tail_pos       = (tail_pos + 1) % DEPTH;
					fill           = fill + 1;
					push_result('0, 1'b1, STAT_OK);
				end else begin
					push_result('0, 1'b1, STAT_FULL);
				end
			end
			OP_ERASE: begin
				k        = (n < fill) ? n : fill;
				head_pos = (head_pos + k) % DEPTH;
				fill     = fill - k;
				push_result('0, 1'b1, STAT_OK);
			end
			default: begin
				if (fill == 0) begin
					push_result('0, 1'b1, STAT_EMPTY);
				end else begin
					cnt = fill;
					idx = head_pos;
					// occupancy reported is the post-operation value
					if (op == OP_DRAIN) begin
						head_pos = tail_pos;
						fill     = 0;
					end
					for (k = 0; k < cnt; k++) begin
						push_result(ring[idx], (k + 1 == cnt), STAT_OK);
						idx = (idx + 1) % DEPTH;
					end
				end
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ring_result_t want;
		if (!arst_n) begin
			head_pos = 0;
			tail_pos = 0;
			fill     = 0;
			due_results.delete();
			due_count  = 0;
			mismatches = 0;
		end else begin
			if (strobe === 1'b1) begin
				if (due_results.size() == 0) begin
					$error("unexpected result transaction: out_byte %0h status %0d",
						out_byte, status);
					mismatches++;
				end else begin
					want = due_results.pop_front();
					if (out_byte !== want.value) begin
						$error("out_byte: expected %0h, got %0h", want.value, out_byte);
						mismatches++;
					end
					if (last !== want.is_last) begin
						$error("last: expected %0d, got %0d", want.is_last, last);
						mismatches++;
					end
					if (status !== want.stat) begin
						$error("status: expected %0d, got %0d", want.stat, status);
						mismatches++;
					end
					if (occupancy !== want.occ) begin
						$error("occupancy: expected %0d, got %0d", want.occ, occupancy);
						mismatches++;
					end
					if (full_res !== want.full) begin
						$error("full_res: expected %0d, got %0d", want.full, full_res);
						mismatches++;
					end
				end
			end
			if (start && !busy)
				apply_ring_op(op_t'(opcode), data_byte, erase_count);
			due_count = due_results.size();
		end
	end

endmodule

`default_nettype wire

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the byte ring buffer: directed corner cases (empty drain and
// peek, erase clamping, full drops), then random command transactions with
// fill-to-full runs, random gaps and drain pauses. Checking is done by
// brb_checker; a watchdog ends the run if nothing moves for too long.
// ----------------------------------------------------------------------------
`default_nettype none

module tb import brb_pkg::*; ();

	localparam int DEPTH       = 64;
	localparam int ITEMS       = 420;
	localparam int STALL_LIMIT = 2000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [1:0]        opcode = OP_WRITE;
	logic [BYTE_W-1:0] data_byte = '0;
	logic [CNT_W-1:0]  erase_count = '0;
	logic              busy;
	logic              strobe;
	logic [BYTE_W-1:0] out_byte;
	logic              last;
	logic [1:0]        status;
	logic [CNT_W-1:0]  occupancy;
	logic              full_res;

	int mismatches;
	int due_count;
	int sent = 0;
	int quiet_cycles = 0;
	bit gaps_on = 1'b1;
	bit paused_once = 1'b0;

	always #1 clk = ~clk;

	byte_ring_buffer_peek_erase #(.DEPTH(DEPTH)) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.opcode      (opcode),
		.data_byte   (data_byte),
		.erase_count (erase_count),
		.strobe      (strobe),
		.out_byte    (out_byte),
		.last        (last),
		.status      (status),
		.occupancy   (occupancy),
		.full_res    (full_res)
	);

	brb_checker #(.DEPTH(DEPTH)) u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.opcode      (opcode),
		.data_byte   (data_byte),
		.erase_count (erase_count),
		.strobe      (strobe),
		.out_byte    (out_byte),
		.last        (last),
		.status      (status),
		.occupancy   (occupancy),
		.full_res    (full_res),
		.mismatches  (mismatches),
		.due_count   (due_count)
	);

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe === 1'b1) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic issue(op_t op, logic [BYTE_W-1:0] d, logic [CNT_W-1:0] n);
		while (gaps_on && $urandom_range(0, 99) < 6) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start       <= 1'b1;
		opcode      <= op;
		data_byte   <= d;
		erase_count <= n;
		do @(posedge clk); while (busy);
		sent++;
		@(negedge clk);
	endtask

	task automatic write_byte(logic [BYTE_W-1:0] d);
		issue(OP_WRITE, d, CNT_W'($urandom));
	endtask

	task automatic other_op(op_t op, logic [CNT_W-1:0] n);
		issue(op, BYTE_W'($urandom), n);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(negedge clk);
		while (due_count != 0) @(negedge clk);
	endtask

	// empty the ring, overfill it so the last writes are dropped, then peek and erase
	task automatic fill_past_full();
		other_op(OP_DRAIN, CNT_W'($urandom));
		repeat (DEPTH + 2) write_byte(BYTE_W'($urandom));
		other_op(OP_PEEK, CNT_W'($urandom));
		other_op(OP_ERASE, CNT_W'($urandom_range(1, DEPTH - 1)));
	endtask

	task automatic random_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			write_byte(BYTE_W'($urandom));
		else if (r < 70)
			other_op(OP_ERASE, ($urandom_range(0, 3) != 0) ?
				CNT_W'($urandom_range(0, 4)) : CNT_W'($urandom_range(0, DEPTH)));
		else if (r < 85)
			other_op(OP_PEEK, CNT_W'($urandom));
		else
			other_op(OP_DRAIN, CNT_W'($urandom));
	endtask

	initial begin
		int r;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		other_op(OP_DRAIN, 7'd0);
		other_op(OP_PEEK, 7'd0);
		other_op(OP_ERASE, 7'd0);
		other_op(OP_ERASE, 7'd64);
		write_byte(8'h00);
		write_byte(8'hFF);
		write_byte(8'hA5);
		other_op(OP_PEEK, 7'd0);
		other_op(OP_ERASE, 7'd1);
		other_op(OP_PEEK, 7'd127);
		other_op(OP_ERASE, 7'd64);
		other_op(OP_PEEK, 7'd0);
		write_byte(8'h01);
		write_byte(8'h02);
		write_byte(8'h03);
		other_op(OP_DRAIN, 7'd0);
		other_op(OP_DRAIN, 7'd0);
		write_byte(8'h5A);
		other_op(OP_ERASE, 7'd0);
		other_op(OP_PEEK, 7'd0);
		other_op(OP_ERASE, 7'd2);
		write_byte(8'h80);
		write_byte(8'h7F);
		other_op(OP_DRAIN, 7'd0);

		fill_past_full();

		while (sent < ITEMS) begin
			gaps_on = !(sent >= 150 && sent < 260);
			r = $urandom_range(0, 99);
			if (!paused_once && sent >= 200) begin
				wait_drained();
				paused_once = 1'b1;
			end else if (r < 4 && sent < ITEMS - 80) begin
				fill_past_full();
			end else if (r < 7) begin
				wait_drained();
			end else begin
				random_op();
			end
		end

		wait_drained();
		repeat (4) @(negedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire
